@@ hw/rtl/ssp_pkg.sv @@
// Shared constants and types for the sprite screen projection block.
`default_nettype none
package ssp_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int SCREEN_BITS = 12;

   localparam int POS_W  = 32;
   localparam int VEC_W  = 19;
   localparam int OFS_W  = POS_W + 1;
   localparam int PROD_W = VEC_W + OFS_W;
   localparam int NUM_W  = PROD_W + 1;
   localparam int DETP_W = 2 * VEC_W;
   localparam int DET_W  = DETP_W + 1;

   localparam int DQ_W   = 32;
   localparam int SUM_W  = DQ_W + 1;
   localparam int CNUM_W = SUM_W + SCREEN_BITS + 1;
   localparam int CABS_W = CNUM_W - 1;
   localparam int CDEN_W = DQ_W + 1;
   localparam int QC_W   = 16;
   localparam int HN_W   = SCREEN_BITS + FRAC_BITS;

   localparam int CC_W   = 16;
   localparam int SIZE_W = 15;
   localparam int BND_W  = 18;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 32;

   localparam logic signed [DQ_W-1:0] DQ_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DQ_W-1:0] DQ_MIN = 32'sh8000_0000;
   localparam logic signed [CC_W-1:0] CC_MAX = 16'sh7FFF;
   localparam logic signed [CC_W-1:0] CC_MIN = 16'sh8000;
   localparam logic [SIZE_W-1:0]      SIZE_MAX = 15'h7FFF;

   localparam logic signed [VEC_W-1:0] DIR_X_RST   = 19'sd65536;
   localparam logic signed [VEC_W-1:0] DIR_Y_RST   = 19'sd0;
   localparam logic signed [VEC_W-1:0] PLANE_X_RST = 19'sd0;
   localparam logic signed [VEC_W-1:0] PLANE_Y_RST = 19'sd43254;
   localparam logic [SCREEN_BITS-1:0]  SCREEN_W_RST = 12'd640;
   localparam logic [SCREEN_BITS-1:0]  SCREEN_H_RST = 12'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CAM_X    = 3'd0,
      REG_CAM_Y    = 3'd1,
      REG_DIR_X    = 3'd2,
      REG_DIR_Y    = 3'd3,
      REG_PLANE_X  = 3'd4,
      REG_PLANE_Y  = 3'd5,
      REG_SCREEN_W = 3'd6,
      REG_SCREEN_H = 3'd7
   } csr_reg_type;

endpackage
`default_nettype wire

@@ hw/rtl/ssp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with tag and valid.
`default_nettype none
module ssp_div #(
   parameter int DW = ssp_pkg::DET_W,
   parameter int QW = ssp_pkg::DQ_W,
   parameter int TW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          vld_in,
   input  wire logic [DW-1:0] rem_in,
   input  wire logic [QW-1:0] low_in,
   input  wire logic [DW-1:0] den_in,
   input  wire logic [TW-1:0] tag_in,
   output logic               vld_out,
   output logic [QW-1:0]      quo_out,
   output logic [TW-1:0]      tag_out
);

   logic [QW-1:0] vld_ff;
   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [TW-1:0] tag_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic          vld_prev;
      logic [DW-1:0] rem_prev;
      logic [QW-1:0] low_prev;
      logic [DW-1:0] den_prev;
      logic [TW-1:0] tag_prev;
      logic [DW:0]   trial;
      logic [DW+1:0] diff;
      logic          ge;

      if (s == 0) begin : g_first
         assign vld_prev = vld_in;
         assign rem_prev = rem_in;
         assign low_prev = low_in;
         assign den_prev = den_in;
         assign tag_prev = tag_in;
      end else begin : g_next
         assign vld_prev = vld_ff[s-1];
         assign rem_prev = rem_ff[s-1];
         assign low_prev = low_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign tag_prev = tag_ff[s-1];
      end

      assign trial = {rem_prev, low_prev[QW-1]};
      assign diff  = {1'b0, trial} - {2'b00, den_prev};
      assign ge    = !diff[DW+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            low_ff[s] <= {low_prev[QW-2:0], ge};
            den_ff[s] <= den_prev;
            tag_ff[s] <= tag_prev;
         end
      end
   end

   assign vld_out = vld_ff[QW-1];
   assign quo_out = low_ff[QW-1];
   assign tag_out = tag_ff[QW-1];

endmodule
`default_nettype wire

@@ hw/rtl/sprite_screen_projection.sv @@
// Sprite screen projection: camera-space depth, screen column, size and draw bounds.
//
// Usage: program the camera through the csr_ write port (index, data, write
// enable) while the block is idle. Each request carries one sprite world
// position (Q16.16); each response carries depth, center column, size, the
// clamped draw columns and rows and the degenerate flag.
// One request is taken every cycle while req_stall is low; the depth and
// offset divisions are 32-stage bit-per-stage pipelines and the column and
// size divisions 16-stage ones, which make up most of the latency.
// Reset clears all valid bits and loads the default camera registers.
// When the receiver stalls with a response pending, the whole pipeline holds
// and req_stall rises in the same cycle; nothing is dropped or repeated.
`default_nettype none
module sprite_screen_projection (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_wr_en,
   input  wire logic [ssp_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [ssp_pkg::CSR_W-1:0]              csr_wdata,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [ssp_pkg::POS_W-1:0]       req_sprite_x,
   input  wire logic signed [ssp_pkg::POS_W-1:0]       req_sprite_y,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [ssp_pkg::DQ_W-1:0]             rsp_depth,
   output logic signed [ssp_pkg::CC_W-1:0]             rsp_center_col,
   output logic [ssp_pkg::SIZE_W-1:0]                  rsp_size_px,
   output logic [ssp_pkg::SIZE_W-1:0]                  rsp_start_col,
   output logic signed [ssp_pkg::CC_W-1:0]             rsp_end_col,
   output logic [ssp_pkg::SIZE_W-1:0]                  rsp_start_row,
   output logic signed [ssp_pkg::CC_W-1:0]             rsp_end_row,
   output logic                                        rsp_degenerate
);

   // camera registers
   logic signed [ssp_pkg::POS_W-1:0] cam_x_ff, cam_y_ff;
   logic signed [ssp_pkg::VEC_W-1:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic [ssp_pkg::SCREEN_BITS-1:0]  screen_w_ff, screen_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff    <= '0;
         cam_y_ff    <= '0;
         dir_x_ff    <= ssp_pkg::DIR_X_RST;
         dir_y_ff    <= ssp_pkg::DIR_Y_RST;
         plane_x_ff  <= ssp_pkg::PLANE_X_RST;
         plane_y_ff  <= ssp_pkg::PLANE_Y_RST;
         screen_w_ff <= ssp_pkg::SCREEN_W_RST;
         screen_h_ff <= ssp_pkg::SCREEN_H_RST;
      end else if (csr_wr_en) begin
         unique case (ssp_pkg::csr_reg_type'(csr_index))
            ssp_pkg::REG_CAM_X:    cam_x_ff    <= csr_wdata[ssp_pkg::POS_W-1:0];
            ssp_pkg::REG_CAM_Y:    cam_y_ff    <= csr_wdata[ssp_pkg::POS_W-1:0];
            ssp_pkg::REG_DIR_X:    dir_x_ff    <= csr_wdata[ssp_pkg::VEC_W-1:0];
            ssp_pkg::REG_DIR_Y:    dir_y_ff    <= csr_wdata[ssp_pkg::VEC_W-1:0];
            ssp_pkg::REG_PLANE_X:  plane_x_ff  <= csr_wdata[ssp_pkg::VEC_W-1:0];
            ssp_pkg::REG_PLANE_Y:  plane_y_ff  <= csr_wdata[ssp_pkg::VEC_W-1:0];
            ssp_pkg::REG_SCREEN_W: screen_w_ff <= csr_wdata[ssp_pkg::SCREEN_BITS-1:0];
            ssp_pkg::REG_SCREEN_H: screen_h_ff <= csr_wdata[ssp_pkg::SCREEN_BITS-1:0];
         endcase
      end
   end

   // determinant, derived from the camera registers
   logic signed [ssp_pkg::DETP_W-1:0] detp1_ff, detp2_ff;
   logic signed [ssp_pkg::DET_W-1:0]  det_ff;
   logic [ssp_pkg::DET_W-1:0]         dabs_ff;
   logic                              dneg_ff, dzero_ff;

   always_ff @(posedge clock) begin
      detp1_ff <= plane_y_ff * dir_y_ff;
      detp2_ff <= dir_x_ff * plane_x_ff;
      det_ff   <= {detp1_ff[ssp_pkg::DETP_W-1], detp1_ff}
                - {detp2_ff[ssp_pkg::DETP_W-1], detp2_ff};
      dabs_ff  <= det_ff[ssp_pkg::DET_W-1] ? ssp_pkg::DET_W'(-det_ff)
                                           : ssp_pkg::DET_W'(det_ff);
      dneg_ff  <= det_ff[ssp_pkg::DET_W-1];
      dzero_ff <= (det_ff == '0);
   end

   logic en;
   logic rsp_valid_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // S1: offsets
   logic                             v1_ff;
   logic signed [ssp_pkg::OFS_W-1:0] dx_ff, dy_ff;
   // S2: products
   logic                              v2_ff;
   logic signed [ssp_pkg::PROD_W-1:0] p_vy_dx_ff, p_vx_dy_ff, p_py_dy_ff, p_px_dx_ff;
   // S3: numerators
   logic                             v3_ff;
   logic signed [ssp_pkg::NUM_W-1:0] ntx_ff, nd_ff;
   // S4: magnitudes
   logic                      v4_ff;
   logic [ssp_pkg::NUM_W-1:0] tabs_ff, nabs_ff;
   logic                      tneg4_ff, dneg4_ff;
   // S5: divider setup
   logic                      v5_ff;
   logic [ssp_pkg::DET_W-1:0] rd_ff, rt_ff, den5_ff;
   logic [ssp_pkg::DQ_W-1:0]  ld_ff, lt_ff;
   logic                      od_ff, ot_ff, dn5_ff, tn5_ff, dz5_ff;

   logic [ssp_pkg::NUM_W-1:0]            rfull_d, rfull_t;
   logic [ssp_pkg::NUM_W+ssp_pkg::FRAC_BITS-1:0] lfull_d, lfull_t;
   logic                                 ovf_d, ovf_t;

   assign rfull_d = nabs_ff >> (ssp_pkg::DQ_W - ssp_pkg::FRAC_BITS);
   assign rfull_t = tabs_ff >> (ssp_pkg::DQ_W - ssp_pkg::FRAC_BITS);
   assign ovf_d   = rfull_d >= ssp_pkg::NUM_W'(dabs_ff);
   assign ovf_t   = rfull_t >= ssp_pkg::NUM_W'(dabs_ff);
   assign lfull_d = {nabs_ff, {ssp_pkg::FRAC_BITS{1'b0}}};
   assign lfull_t = {tabs_ff, {ssp_pkg::FRAC_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= {req_sprite_x[ssp_pkg::POS_W-1], req_sprite_x}
                - {cam_x_ff[ssp_pkg::POS_W-1], cam_x_ff};
         dy_ff <= {req_sprite_y[ssp_pkg::POS_W-1], req_sprite_y}
                - {cam_y_ff[ssp_pkg::POS_W-1], cam_y_ff};

         p_vy_dx_ff <= dir_y_ff * dx_ff;
         p_vx_dy_ff <= dir_x_ff * dy_ff;
         p_py_dy_ff <= plane_y_ff * dy_ff;
         p_px_dx_ff <= plane_x_ff * dx_ff;

         ntx_ff <= {p_vy_dx_ff[ssp_pkg::PROD_W-1], p_vy_dx_ff}
                 - {p_vx_dy_ff[ssp_pkg::PROD_W-1], p_vx_dy_ff};
         nd_ff  <= {p_py_dy_ff[ssp_pkg::PROD_W-1], p_py_dy_ff}
                 - {p_px_dx_ff[ssp_pkg::PROD_W-1], p_px_dx_ff};

         tabs_ff  <= ntx_ff[ssp_pkg::NUM_W-1] ? ssp_pkg::NUM_W'(-ntx_ff)
                                              : ssp_pkg::NUM_W'(ntx_ff);
         nabs_ff  <= nd_ff[ssp_pkg::NUM_W-1] ? ssp_pkg::NUM_W'(-nd_ff)
                                             : ssp_pkg::NUM_W'(nd_ff);
         tneg4_ff <= ntx_ff[ssp_pkg::NUM_W-1] ^ dneg_ff;
         dneg4_ff <= nd_ff[ssp_pkg::NUM_W-1] ^ dneg_ff;

         rd_ff   <= ovf_d ? '0 : rfull_d[ssp_pkg::DET_W-1:0];
         rt_ff   <= ovf_t ? '0 : rfull_t[ssp_pkg::DET_W-1:0];
         ld_ff   <= lfull_d[ssp_pkg::DQ_W-1:0];
         lt_ff   <= lfull_t[ssp_pkg::DQ_W-1:0];
         od_ff   <= ovf_d;
         ot_ff   <= ovf_t;
         den5_ff <= dabs_ff;
         dn5_ff  <= dneg4_ff;
         tn5_ff  <= tneg4_ff;
         dz5_ff  <= dzero_ff;
      end
   end

   // depth and offset dividers
   logic                     va_out, vb_out;
   logic [ssp_pkg::DQ_W-1:0] qa, qb;
   logic [2:0]               tag_a;
   logic [1:0]               tag_b;

   ssp_div #(.DW(ssp_pkg::DET_W), .QW(ssp_pkg::DQ_W), .TW(3)) u_div_depth (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .vld_in  (v5_ff),
      .rem_in  (rd_ff),
      .low_in  (ld_ff),
      .den_in  (den5_ff),
      .tag_in  ({dn5_ff, od_ff, dz5_ff}),
      .vld_out (va_out),
      .quo_out (qa),
      .tag_out (tag_a)
   );

   ssp_div #(.DW(ssp_pkg::DET_W), .QW(ssp_pkg::DQ_W), .TW(2)) u_div_tx (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .vld_in  (v5_ff),
      .rem_in  (rt_ff),
      .low_in  (lt_ff),
      .den_in  (den5_ff),
      .tag_in  ({tn5_ff, ot_ff}),
      .vld_out (vb_out),
      .quo_out (qb),
      .tag_out (tag_b)
   );

   // S6: saturate depth and offset
   logic                            sat_a, sat_b;
   logic signed [ssp_pkg::DQ_W-1:0] dq_in, tx_in;
   logic                            degen6_in;

   assign sat_a = tag_a[1] | qa[ssp_pkg::DQ_W-1];
   assign sat_b = tag_b[0] | qb[ssp_pkg::DQ_W-1];

   always_comb begin
      if (tag_a[0]) begin
         dq_in = ssp_pkg::DQ_MAX;
      end else if (tag_a[2]) begin
         dq_in = sat_a ? ssp_pkg::DQ_MIN : $signed(ssp_pkg::DQ_W'(-qa));
      end else begin
         dq_in = sat_a ? ssp_pkg::DQ_MAX : $signed(qa);
      end
      if (tag_b[1]) begin
         tx_in = sat_b ? ssp_pkg::DQ_MIN : $signed(ssp_pkg::DQ_W'(-qb));
      end else begin
         tx_in = sat_b ? ssp_pkg::DQ_MAX : $signed(qb);
      end
      degen6_in = tag_a[0] | (!tag_a[1] && qa == '0);
   end

   logic                            v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   logic signed [ssp_pkg::DQ_W-1:0] dq6_ff, tx6_ff, dq7_ff, dq8_ff, dq9_ff, dq10_ff;
   logic                            dg6_ff, dg7_ff, dg8_ff, dg9_ff, dg10_ff;
   logic signed [ssp_pkg::SUM_W-1:0]  sum7_ff;
   logic [ssp_pkg::DQ_W-1:0]          dqa7_ff, dqa8_ff, dqa9_ff, dqa10_ff;
   logic                              dqn7_ff, dqn8_ff;
   logic signed [ssp_pkg::CNUM_W-1:0] cnum8_ff;
   logic [ssp_pkg::CABS_W-1:0]        cabs9_ff;
   logic                              cneg9_ff, cneg10_ff;
   logic [ssp_pkg::CDEN_W-1:0]        crem10_ff, cden10_ff;
   logic [ssp_pkg::QC_W-1:0]          clow10_ff, hlow10_ff;
   logic                              covf10_ff, hovf10_ff;
   logic [ssp_pkg::DQ_W-1:0]          hrem10_ff;

   logic [ssp_pkg::CNUM_W-1:0] cabs_w;
   logic [ssp_pkg::CABS_W-1:0] crem_full;
   logic [ssp_pkg::CDEN_W-1:0] cden_w;
   logic                       covf_w;
   logic [ssp_pkg::HN_W-1:0]   hnum, hrem_full;
   logic                       hovf_w;

   assign cabs_w    = cnum8_ff[ssp_pkg::CNUM_W-1] ? ssp_pkg::CNUM_W'(-cnum8_ff)
                                                  : ssp_pkg::CNUM_W'(cnum8_ff);
   assign cden_w    = {dqa9_ff, 1'b0};
   assign crem_full = cabs9_ff >> ssp_pkg::QC_W;
   assign covf_w    = crem_full >= ssp_pkg::CABS_W'(cden_w);
   assign hnum      = {screen_h_ff, {ssp_pkg::FRAC_BITS{1'b0}}};
   assign hrem_full = hnum >> ssp_pkg::QC_W;
   assign hovf_w    = ssp_pkg::DQ_W'(hrem_full) >= dqa9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
      end else if (en) begin
         v6_ff  <= va_out & vb_out;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dq6_ff <= dq_in;
         tx6_ff <= tx_in;
         dg6_ff <= degen6_in;

         sum7_ff <= {dq6_ff[ssp_pkg::DQ_W-1], dq6_ff} + {tx6_ff[ssp_pkg::DQ_W-1], tx6_ff};
         dqa7_ff <= dq6_ff[ssp_pkg::DQ_W-1] ? ssp_pkg::DQ_W'(-dq6_ff)
                                            : ssp_pkg::DQ_W'(dq6_ff);
         dqn7_ff <= dq6_ff[ssp_pkg::DQ_W-1];
         dq7_ff  <= dq6_ff;
         dg7_ff  <= dg6_ff;

         cnum8_ff <= $signed({1'b0, screen_w_ff}) * sum7_ff;
         dqa8_ff  <= dqa7_ff;
         dqn8_ff  <= dqn7_ff;
         dq8_ff   <= dq7_ff;
         dg8_ff   <= dg7_ff;

         cabs9_ff <= cabs_w[ssp_pkg::CABS_W-1:0];
         cneg9_ff <= cnum8_ff[ssp_pkg::CNUM_W-1] ^ dqn8_ff;
         dqa9_ff  <= dqa8_ff;
         dq9_ff   <= dq8_ff;
         dg9_ff   <= dg8_ff;

         crem10_ff <= covf_w ? '0 : crem_full[ssp_pkg::CDEN_W-1:0];
         cden10_ff <= cden_w;
         clow10_ff <= cabs9_ff[ssp_pkg::QC_W-1:0];
         covf10_ff <= covf_w;
         cneg10_ff <= cneg9_ff;
         hrem10_ff <= hovf_w ? '0 : ssp_pkg::DQ_W'(hrem_full);
         hlow10_ff <= hnum[ssp_pkg::QC_W-1:0];
         hovf10_ff <= hovf_w;
         dqa10_ff  <= dqa9_ff;
         dq10_ff   <= dq9_ff;
         dg10_ff   <= dg9_ff;
      end
   end

   // center column and size dividers
   logic                     vc_out, vh_out;
   logic [ssp_pkg::QC_W-1:0] qc, qh;
   logic [ssp_pkg::DQ_W+2:0] tag_c;
   logic                     tag_h;

   ssp_div #(.DW(ssp_pkg::CDEN_W), .QW(ssp_pkg::QC_W), .TW(ssp_pkg::DQ_W + 3)) u_div_col (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .vld_in  (v10_ff),
      .rem_in  (crem10_ff),
      .low_in  (clow10_ff),
      .den_in  (cden10_ff),
      .tag_in  ({cneg10_ff, covf10_ff, dg10_ff, dq10_ff}),
      .vld_out (vc_out),
      .quo_out (qc),
      .tag_out (tag_c)
   );

   ssp_div #(.DW(ssp_pkg::DQ_W), .QW(ssp_pkg::QC_W), .TW(1)) u_div_size (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .vld_in  (v10_ff),
      .rem_in  (hrem10_ff),
      .low_in  (hlow10_ff),
      .den_in  (dqa10_ff),
      .tag_in  (hovf10_ff),
      .vld_out (vh_out),
      .quo_out (qh),
      .tag_out (tag_h)
   );

   // S11: saturate column and size
   logic                            c_neg, c_ovf, c_dg;
   logic                            sat_c;
   logic signed [ssp_pkg::CC_W-1:0] cc_in;
   logic [ssp_pkg::SIZE_W-1:0]      h_in;

   assign c_neg = tag_c[ssp_pkg::DQ_W+2];
   assign c_ovf = tag_c[ssp_pkg::DQ_W+1];
   assign c_dg  = tag_c[ssp_pkg::DQ_W];
   assign sat_c = c_ovf | qc[ssp_pkg::QC_W-1];

   always_comb begin
      if (c_dg) begin
         cc_in = $signed(ssp_pkg::CC_W'(screen_w_ff[ssp_pkg::SCREEN_BITS-1:1]));
      end else if (c_neg) begin
         cc_in = sat_c ? ssp_pkg::CC_MIN : $signed(ssp_pkg::CC_W'(-qc));
      end else begin
         cc_in = sat_c ? ssp_pkg::CC_MAX : $signed(qc);
      end
      if (c_dg || tag_h || qh[ssp_pkg::QC_W-1]) begin
         h_in = ssp_pkg::SIZE_MAX;
      end else begin
         h_in = qh[ssp_pkg::SIZE_W-1:0];
      end
   end

   logic                            v11_ff, dg11_ff;
   logic signed [ssp_pkg::CC_W-1:0] cc11_ff;
   logic [ssp_pkg::SIZE_W-1:0]      h11_ff;
   logic signed [ssp_pkg::DQ_W-1:0] dq11_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v11_ff <= 1'b0;
      end else if (en) begin
         v11_ff <= vc_out & vh_out;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cc11_ff <= cc_in;
         h11_ff  <= h_in;
         dg11_ff <= c_dg;
         dq11_ff <= tag_c[ssp_pkg::DQ_W-1:0];
      end
   end

   // S12: draw bounds into the response register
   logic signed [ssp_pkg::BND_W-1:0] cc_x, hh_x, sw_x, sh_x;
   logic signed [ssp_pkg::BND_W-1:0] t_x, er_x, sc_x, ec_x;
   logic [ssp_pkg::SIZE_W-1:0]       srow_in, scol_in;
   logic [ssp_pkg::CC_W-1:0]         erow_in, ecol_in;

   always_comb begin
      cc_x = ssp_pkg::BND_W'(cc11_ff);
      hh_x = $signed(ssp_pkg::BND_W'(h11_ff[ssp_pkg::SIZE_W-1:1]));
      sw_x = $signed(ssp_pkg::BND_W'(screen_w_ff));
      sh_x = $signed(ssp_pkg::BND_W'(screen_h_ff));

      t_x     = sh_x - (hh_x <<< 1);
      srow_in = (t_x < 0) ? '0 : t_x[ssp_pkg::SIZE_W:1];

      er_x = (sh_x + (hh_x <<< 1)) >>> 1;
      if (er_x >= sh_x) begin
         er_x = sh_x - ssp_pkg::BND_W'(1);
      end
      erow_in = er_x[ssp_pkg::CC_W-1:0];

      sc_x    = cc_x - hh_x;
      scol_in = (sc_x < 0) ? '0 : sc_x[ssp_pkg::SIZE_W-1:0];

      ec_x = cc_x + hh_x;
      if (ec_x >= sw_x) begin
         ec_x = sw_x - ssp_pkg::BND_W'(1);
      end
      ecol_in = ec_x[ssp_pkg::CC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v11_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_depth      <= dq11_ff;
         rsp_center_col <= cc11_ff;
         rsp_size_px    <= h11_ff;
         rsp_start_col  <= scol_in;
         rsp_end_col    <= $signed(ecol_in);
         rsp_start_row  <= srow_in;
         rsp_end_row    <= $signed(erow_in);
         rsp_degenerate <= dg11_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire
